// ----- hw/rtl/slfr_pkg.sv -----
// ----------------------------------------------------------------------------
// slfr_pkg
// Shared constants and types for the sync/length frame receiver.
// ----------------------------------------------------------------------------
package slfr_pkg;

	localparam int unsigned BUF_DEPTH_DEF = 32;
	localparam int unsigned SIZE_W        = 9;
	localparam int unsigned POS_W         = 5;
	localparam int unsigned BYTE_W        = 8;

	localparam logic [BYTE_W-1:0] SYNC_FIRST   = 8'h5A;
	localparam logic [BYTE_W-1:0] SYNC_SECOND  = 8'hA5;
	localparam logic [SIZE_W-1:0] HEADER_BYTES = 9'd3;

	typedef struct packed {
		logic              start;
		logic [SIZE_W-1:0] size;
	} slfr_emit_req_t;

	typedef enum logic {
		E_IDLE,
		E_RUN
	} slfr_emit_state_t;

endpackage

// ----- hw/rtl/sync_length_frame_receiver_top.sv -----
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_top
// Hunts for 0x5A 0xA5 <count> frames and replays each complete frame,
// header included, one byte per transfer with the last byte marked.
// ----------------------------------------------------------------------------
// Readout: the first byte of a frame is valid once the sequencer has entered
//   its run state and the frame store has registered the first read.
// Throughput: one input byte per cycle while collecting; readout of the frame
//   store is one RAM read per cycle unless the output stalls; input is held off.
// Reset: arst_n clears the fill count and the readout sequencer; the frame
//   store is not cleared.
module sync_length_frame_receiver_top #(
	parameter int unsigned BUF_DEPTH = slfr_pkg::BUF_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] frame_byte,
	output logic [4:0] byte_position,
	output logic       frame_end
);

	import slfr_pkg::*;

	localparam int unsigned AW = $clog2(BUF_DEPTH);

	slfr_emit_req_t    emit_req;
	logic              emit_busy;
	logic              wr_en, rd_en;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [BYTE_W-1:0] wr_data;

	slfr_collect #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_collect (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.emit_busy(emit_busy),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.emit_req (emit_req)
	);

	slfr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BUF_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(frame_byte)
	);

	slfr_emit #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.emit_req     (emit_req),
		.emit_busy    (emit_busy),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.byte_position(byte_position),
		.frame_end    (frame_end)
	);

endmodule

// ----- hw/rtl/slfr_ram.sv -----
// ----------------------------------------------------------------------------
// slfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slfr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/slfr_collect.sv -----
// ----------------------------------------------------------------------------
// slfr_collect
// Sync hunt and frame fill: writes bytes into the frame store and requests
// emission once the declared frame size is held.
// ----------------------------------------------------------------------------
module slfr_collect #(
	parameter int unsigned BUF_DEPTH = slfr_pkg::BUF_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   rx_byte,
	input  logic                         emit_busy,
	output logic                         wr_en,
	output logic [$clog2(BUF_DEPTH)-1:0] wr_addr,
	output logic [7:0]                   wr_data,
	output slfr_pkg::slfr_emit_req_t     emit_req
);

	import slfr_pkg::*;

	localparam int unsigned AW = $clog2(BUF_DEPTH);
	localparam int unsigned FW = $clog2(BUF_DEPTH + 1);

	logic [FW-1:0]     fill_q, fill_d, fill_inc;
	logic [BYTE_W-1:0] count_q, count_d, cnt_sel;
	logic [SIZE_W-1:0] frame_size;
	logic              accept, start;

	assign in_ready   = !emit_busy;
	assign accept     = in_valid && in_ready;
	assign cnt_sel    = (fill_q == FW'(2)) ? rx_byte : count_q;
	assign frame_size = SIZE_W'(cnt_sel) + HEADER_BYTES;
	assign fill_inc   = fill_q + FW'(1);
	assign wr_addr    = AW'(fill_q);
	assign wr_data    = rx_byte;

	always_comb begin
		fill_d  = fill_q;
		count_d = count_q;
		wr_en   = 1'b0;
		start   = 1'b0;
		if (accept) begin
			if (fill_q == '0) begin
				if (rx_byte == SYNC_FIRST) begin
					wr_en  = 1'b1;
					fill_d = FW'(1);
				end
			end else if (fill_q == FW'(1)) begin
				if (rx_byte == SYNC_SECOND) begin
					wr_en  = 1'b1;
					fill_d = FW'(2);
				end else begin
					fill_d = '0;
				end
			end else if (fill_q < FW'(BUF_DEPTH)) begin
				wr_en = 1'b1;
				if (fill_q == FW'(2)) begin
					count_d = rx_byte;
				end
				if (frame_size > SIZE_W'(BUF_DEPTH)) begin
					fill_d = '0;
				end else if (SIZE_W'(fill_inc) == frame_size) begin
					start  = 1'b1;
					fill_d = '0;
				end else begin
					fill_d = fill_inc;
				end
			end else begin
				fill_d = '0;
			end
		end
	end

	assign emit_req.start = start;
	assign emit_req.size  = frame_size;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		count_q <= count_d;
	end

endmodule

// ----- hw/rtl/slfr_emit.sv -----
// ----------------------------------------------------------------------------
// slfr_emit
// Frame readout sequencer: reads the frame store one entry per transfer,
// the RAM read register doubling as the output data register.
// ----------------------------------------------------------------------------
module slfr_emit #(
	parameter int unsigned BUF_DEPTH = slfr_pkg::BUF_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  slfr_pkg::slfr_emit_req_t     emit_req,
	output logic                         emit_busy,
	output logic                         rd_en,
	output logic [$clog2(BUF_DEPTH)-1:0] rd_addr,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [slfr_pkg::POS_W-1:0]   byte_position,
	output logic                         frame_end
);

	import slfr_pkg::*;

	localparam int unsigned AW = $clog2(BUF_DEPTH);

	slfr_emit_state_t state_q, state_d;
	logic [AW-1:0]    idx_q, last_q;
	logic [POS_W-1:0] pos_q;
	logic             end_q, out_valid_q;

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		case (state_q)
			E_IDLE: begin
				if (emit_req.start) begin
					state_d = E_RUN;
				end
			end
			E_RUN: begin
				rd_en = !out_valid_q || out_ready;
				if (rd_en && idx_q == last_q) begin
					state_d = E_IDLE;
				end
			end
			default: begin
				state_d = E_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= E_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rd_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && emit_req.start) begin
			idx_q  <= '0;
			last_q <= AW'(emit_req.size - SIZE_W'(1));
		end else if (rd_en) begin
			idx_q <= idx_q + AW'(1);
		end
		if (rd_en) begin
			pos_q <= POS_W'(idx_q);
			end_q <= (idx_q == last_q);
		end
	end

	assign emit_busy     = (state_q == E_RUN);
	assign rd_addr       = idx_q;
	assign out_valid     = out_valid_q;
	assign byte_position = pos_q;
	assign frame_end     = end_q;

endmodule

// ----- hw/rtl/slfr_checker.sv -----
// ----------------------------------------------------------------------------
// slfr_checker
// Port-level assertions for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module slfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] frame_byte,
	input logic [4:0] byte_position,
	input logic       frame_end
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_byte)
			&& $stable(byte_position) && $stable(frame_end))
		else $error("output changed while stalled");

	a_no_input_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_end |-> !in_ready)
		else $error("input taken during frame readout");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !frame_end |=>
			out_valid && byte_position == $past(byte_position) + 5'd1)
		else $error("frame readout gap or position skip");

	a_restart_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && frame_end |=> !out_valid || byte_position == 5'd0)
		else $error("frame following an end does not start at position 0");

endmodule

bind sync_length_frame_receiver_top slfr_checker u_slfr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.frame_byte   (frame_byte),
	.byte_position(byte_position),
	.frame_end    (frame_end)
);
